[sv/cas_pkg.sv]
`timescale 1ns / 1ps

package cas_pkg;

    // Payload of one input item: one byte of the address line
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } t_in_item;

    // Payload of one result item: the decoded address line
    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  channel_type;
        logic [6:0]  bit_number;
        logic [31:0] first_index;
        logic [31:0] index_step;
        logic        last_result;
    } t_out_item;

    typedef logic [3:0] t_status;
    typedef logic [3:0] t_ctype;

    // Status codes
    localparam t_status ST_OK               = 4'd0;
    localparam t_status ST_EMPTY            = 4'd1;
    localparam t_status ST_NO_M             = 4'd2;
    localparam t_status ST_BAD_INF          = 4'd3;
    localparam t_status ST_NO_OFFSET        = 4'd4;
    localparam t_status ST_BAD_OFFSET       = 4'd5;
    localparam t_status ST_INCOMPLETE_FIELD = 4'd6;
    localparam t_status ST_BAD_FIELD        = 4'd7;
    localparam t_status ST_INCOMPLETE_T     = 4'd8;
    localparam t_status ST_UNKNOWN_T        = 4'd9;
    localparam t_status ST_MISSING_BIT      = 4'd10;
    localparam t_status ST_BAD_BIT          = 4'd11;
    localparam t_status ST_UNEXPECTED       = 4'd12;

    // Channel type codes
    localparam t_ctype CT_NONE     = 4'd0;
    localparam t_ctype CT_ANALOG10 = 4'd1;
    localparam t_ctype CT_ANALOG9  = 4'd2;
    localparam t_ctype CT_CONTACT  = 4'd3;
    localparam t_ctype CT_TEMP     = 4'd4;
    localparam t_ctype CT_FAST1    = 4'd5;
    localparam t_ctype CT_BUS      = 4'd9;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Informativity that selects the begin offset and doubled indexes
    localparam logic [6:0] INF_DOUBLE = 7'd16;

endpackage

[sv/cas_stream_if.sv]
`timescale 1ns / 1ps

interface cas_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/channel_address_string_parser.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                   | Handshake
// i_in     | in  | char_in[7:0], end_of_line                 | valid/ready
// o_out    | out | status, channel_type, bit_number,          | valid/ready
//          |     | first_index, index_step, last_result      |
//
// One byte is taken per cycle, back to back; the next parser state is computed
// combinationally from the input register (one 32x4 multiply-add and a shift).
// A result moves from the input register through the line snapshot to the output register.
// Reset is synchronous, active low; it clears the parser to its idle state.
// A stalled result waits in the output register while a second result and
// new bytes keep flowing; bytes stall only when a line end finds both full.

module channel_address_string_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cas_stream_if.sink          i_in,
    cas_stream_if.source        o_out
);

    typedef enum logic [15:0] {
        PH_START = 16'h0001,
        PH_INF1  = 16'h0002,
        PH_INF2  = 16'h0004,
        PH_SKIP  = 16'h0008,
        PH_MAIN  = 16'h0010,
        PH_FLD1  = 16'h0020,
        PH_FLD2  = 16'h0040,
        PH_T1    = 16'h0080,
        PH_T2    = 16'h0100,
        PH_T01A  = 16'h0200,
        PH_T01B  = 16'h0400,
        PH_T01C  = 16'h0800,
        PH_C0    = 16'h1000,
        PH_P1    = 16'h2000,
        PH_P2    = 16'h4000,
        PH_DONE  = 16'h8000
    } t_phase;

    typedef struct packed {
        cas_pkg::t_status err;
        logic             t01;
    } t_fin;

    // Pipeline registers
    logic               r_in_valid;
    cas_pkg::t_in_item  r_in;
    logic               r_snap_valid;
    cas_pkg::t_status   r_snap_status;
    cas_pkg::t_ctype    r_snap_type;
    logic [6:0]         r_snap_bit;
    logic [31:0]        r_snap_off;
    logic [31:0]        r_snap_step;
    logic [1:0]         r_snap_begin;
    logic               r_out_valid;
    cas_pkg::t_out_item r_out;

    // Parser state
    t_phase             r_phase, n_phase;
    logic [6:0]         r_inf, n_inf;
    logic [1:0]         r_begin, n_begin;
    logic [31:0]        r_off, n_off;
    logic [31:0]        r_step, n_step;
    logic [7:0]         r_held, n_held;
    cas_pkg::t_ctype    r_type, n_type;
    logic [6:0]         r_bit, n_bit;
    cas_pkg::t_status   r_err, n_err;

    logic               w_out_adv;
    logic               w_snap_adv;
    logic               w_in_take;
    logic               w_in_adv;
    logic               w_dbl;

    function automatic logic f_dig(input logic [7:0] ch);
        return (ch >= cas_pkg::CH_0) && (ch <= cas_pkg::CH_9);
    endfunction

    function automatic logic [7:0] f_upper(input logic [7:0] ch);
        logic [7:0] up;
        up = ch;
        if (ch >= cas_pkg::CH_LO_A && ch <= cas_pkg::CH_LO_Z) begin
            up = ch - cas_pkg::CASE_GAP;
        end
        return up;
    endfunction

    // Outcome of a line ending in the given phase
    function automatic t_fin f_finish(input t_phase ph);
        t_fin f;
        f = '0;
        case (ph)
            PH_START:                   f.err = cas_pkg::ST_EMPTY;
            PH_INF1, PH_INF2:           f.err = cas_pkg::ST_BAD_INF;
            PH_SKIP:                    f.err = cas_pkg::ST_NO_OFFSET;
            PH_FLD1, PH_FLD2:           f.err = cas_pkg::ST_INCOMPLETE_FIELD;
            PH_T1, PH_T2:               f.err = cas_pkg::ST_INCOMPLETE_T;
            PH_T01A, PH_T01B, PH_T01C:  f.t01 = 1'b1;
            PH_P1, PH_P2:               f.err = cas_pkg::ST_MISSING_BIT;
            default:                    f = '0;
        endcase
        return f;
    endfunction

    // Pipeline advance: output, line snapshot, input register
    assign w_out_adv  = !r_out_valid || o_out.ready;
    assign w_snap_adv = !r_snap_valid || w_out_adv;
    assign w_in_take  = r_in_valid && (!r_in.end_of_line || w_snap_adv);
    assign w_in_adv   = !r_in_valid || w_in_take;
    assign i_in.ready = w_in_adv;

    // Next parser state for the byte in the input register
    always_comb begin
        logic [7:0]  c;
        logic [7:0]  u;
        logic [3:0]  dc;
        logic [3:0]  dh;
        logic [31:0] prod;
        t_fin        fin;

        n_phase = r_phase;
        n_inf   = r_inf;
        n_begin = r_begin;
        n_off   = r_off;
        n_step  = r_step;
        n_held  = r_held;
        n_type  = r_type;
        n_bit   = r_bit;
        n_err   = r_err;
        fin  = '0;
        c    = r_in.char_in;
        u    = f_upper(c);
        dc   = c[3:0];
        dh   = r_held[3:0];
        prod = r_step * {28'd0, dh};

        if (r_phase != PH_DONE) begin
            if (c == cas_pkg::CH_SPACE || c == cas_pkg::CH_TAB) begin
                fin = f_finish(r_phase);
                if (fin.err != cas_pkg::ST_OK) n_err = fin.err;
                if (fin.t01) n_type = cas_pkg::CT_ANALOG10;
                n_phase = PH_DONE;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (u == cas_pkg::CH_M) begin
                            n_phase = PH_INF1;
                        end else begin
                            n_err = cas_pkg::ST_NO_M; n_phase = PH_DONE;
                        end
                    end
                    PH_INF1: begin
                        if (f_dig(c)) begin
                            n_inf   = 7'({3'd0, dc} * 7'd10);
                            n_phase = PH_INF2;
                        end else begin
                            n_err = cas_pkg::ST_BAD_INF; n_phase = PH_DONE;
                        end
                    end
                    PH_INF2: begin
                        if (f_dig(c)) begin
                            n_inf   = r_inf + {3'd0, dc};
                            n_phase = (n_inf == cas_pkg::INF_DOUBLE) ? PH_SKIP : PH_MAIN;
                        end else begin
                            n_err = cas_pkg::ST_BAD_INF; n_phase = PH_DONE;
                        end
                    end
                    PH_SKIP: begin
                        if (c == cas_pkg::CH_1 || c == cas_pkg::CH_2) begin
                            n_begin = dc[1:0];
                            n_phase = PH_MAIN;
                        end else if (f_dig(c)) begin
                            n_err = cas_pkg::ST_BAD_OFFSET; n_phase = PH_DONE;
                        end
                    end
                    PH_MAIN: begin
                        if ((u >= cas_pkg::CH_A && u <= cas_pkg::CH_E) || u == cas_pkg::CH_X)
                        begin
                            n_phase = PH_FLD1;
                        end else if (u == cas_pkg::CH_T) begin
                            n_phase = PH_T1;
                        end else begin
                            n_err = cas_pkg::ST_UNEXPECTED; n_phase = PH_DONE;
                        end
                    end
                    PH_FLD1: begin
                        n_held = c; n_phase = PH_FLD2;
                    end
                    PH_FLD2: begin
                        // offset += (value - 1) * step, step *= factor
                        if (f_dig(r_held) && f_dig(c)) begin
                            n_off = r_off + prod - r_step;
                            if (dc == 4'd0) begin
                                n_step = {r_step[28:0], 3'b000};
                            end else if (dc == 4'd1) begin
                                n_step = {r_step[29:0], 2'b00};
                            end else begin
                                n_step = {r_step[30:0], 1'b0};
                            end
                            n_phase = PH_MAIN;
                        end else begin
                            n_err = cas_pkg::ST_BAD_FIELD; n_phase = PH_DONE;
                        end
                    end
                    PH_T1: begin
                        n_held = c; n_phase = PH_T2;
                    end
                    PH_T2: begin
                        if (r_held == cas_pkg::CH_0 && c == cas_pkg::CH_1) begin
                            n_phase = PH_T01A;
                        end else if (r_held == cas_pkg::CH_0 && c == cas_pkg::CH_5) begin
                            n_type = cas_pkg::CT_CONTACT; n_phase = PH_C0;
                        end else if (r_held == cas_pkg::CH_1 && c == cas_pkg::CH_1) begin
                            n_type = cas_pkg::CT_TEMP; n_phase = PH_DONE;
                        end else if (r_held == cas_pkg::CH_2 && c >= cas_pkg::CH_1 &&
                                     c <= cas_pkg::CH_4) begin
                            n_type  = cas_pkg::CT_FAST1 + dc - 4'd1;
                            n_phase = PH_DONE;
                        end else if (r_held == cas_pkg::CH_2 && c == cas_pkg::CH_5) begin
                            n_type = cas_pkg::CT_BUS; n_phase = PH_DONE;
                        end else begin
                            n_err = cas_pkg::ST_UNKNOWN_T; n_phase = PH_DONE;
                        end
                    end
                    PH_T01A: begin
                        if (c == cas_pkg::CH_MINUS) begin
                            n_phase = PH_T01B;
                        end else begin
                            n_type = cas_pkg::CT_ANALOG10; n_phase = PH_DONE;
                        end
                    end
                    PH_T01B: begin
                        if (c == cas_pkg::CH_0) begin
                            n_phase = PH_T01C;
                        end else begin
                            n_type = cas_pkg::CT_ANALOG10; n_phase = PH_DONE;
                        end
                    end
                    PH_T01C: begin
                        n_type  = (c == cas_pkg::CH_1) ? cas_pkg::CT_ANALOG9
                                                       : cas_pkg::CT_ANALOG10;
                        n_phase = PH_DONE;
                    end
                    PH_C0: begin
                        n_phase = (u == cas_pkg::CH_P) ? PH_P1 : PH_DONE;
                    end
                    PH_P1: begin
                        n_held = c; n_phase = PH_P2;
                    end
                    PH_P2: begin
                        if (f_dig(r_held) && f_dig(c)) begin
                            n_bit = 7'({3'd0, dh} * 7'd10) + {3'd0, dc};
                        end else begin
                            n_err = cas_pkg::ST_BAD_BIT;
                        end
                        n_phase = PH_DONE;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end

        // Close the line on its last byte
        if (r_in.end_of_line && n_phase != PH_DONE) begin
            fin = f_finish(n_phase);
            if (fin.err != cas_pkg::ST_OK) n_err = fin.err;
            if (fin.t01) n_type = cas_pkg::CT_ANALOG10;
            n_phase = PH_DONE;
        end
    end

    assign w_dbl = (n_inf == cas_pkg::INF_DOUBLE);

    // Control state and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_START;
            r_inf        <= '0;
            r_begin      <= 2'd1;
            r_off        <= '0;
            r_step       <= 32'd1;
            r_type       <= cas_pkg::CT_NONE;
            r_bit        <= '0;
            r_err        <= cas_pkg::ST_OK;
        end else begin
            if (w_in_adv) r_in_valid <= i_in.valid;
            if (w_snap_adv) r_snap_valid <= w_in_take && r_in.end_of_line;
            if (w_out_adv) r_out_valid <= r_snap_valid;
            // Advance the parser, back to idle after each line
            if (w_in_take) begin
                if (r_in.end_of_line) begin
                    r_phase <= PH_START;
                    r_inf   <= '0;
                    r_begin <= 2'd1;
                    r_off   <= '0;
                    r_step  <= 32'd1;
                    r_type  <= cas_pkg::CT_NONE;
                    r_bit   <= '0;
                    r_err   <= cas_pkg::ST_OK;
                end else begin
                    r_phase <= n_phase;
                    r_inf   <= n_inf;
                    r_begin <= n_begin;
                    r_off   <= n_off;
                    r_step  <= n_step;
                    r_type  <= n_type;
                    r_bit   <= n_bit;
                    r_err   <= n_err;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_in.valid) r_in <= i_in.data;
        if (w_in_take) r_held <= n_held;
        // Capture the finished line; an error zeroes the descriptor
        if (w_snap_adv && w_in_take && r_in.end_of_line) begin
            r_snap_status <= n_err;
            if (n_err != cas_pkg::ST_OK) begin
                r_snap_type  <= cas_pkg::CT_NONE;
                r_snap_bit   <= '0;
                r_snap_off   <= '0;
                r_snap_step  <= '0;
                r_snap_begin <= '0;
            end else begin
                r_snap_type  <= n_type;
                r_snap_bit   <= n_bit;
                r_snap_off   <= w_dbl ? {n_off[30:0], 1'b0} : n_off;
                r_snap_step  <= w_dbl ? {n_step[30:0], 1'b0} : n_step;
                r_snap_begin <= n_begin;
            end
        end
        if (w_out_adv && r_snap_valid) begin
            r_out.status       <= r_snap_status;
            r_out.channel_type <= r_snap_type;
            r_out.bit_number   <= r_snap_bit;
            r_out.first_index  <= r_snap_off + {30'd0, r_snap_begin};
            r_out.index_step   <= r_snap_step;
            r_out.last_result  <= 1'b1;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status != cas_pkg::ST_OK) |->
        (o_out.data.channel_type == cas_pkg::CT_NONE && o_out.data.bit_number == 7'd0 &&
         o_out.data.first_index == 32'd0 && o_out.data.index_step == 32'd0))
        else $error("error result carries nonzero descriptor");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.status <= cas_pkg::ST_UNEXPECTED &&
                         o_out.data.last_result))
        else $error("result status out of range or last flag low");

    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && r_in.end_of_line) |=> (r_phase == PH_START && r_err == cas_pkg::ST_OK))
        else $error("parser not idle after line end");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !w_out_adv) |=> (r_snap_valid && $stable(r_snap_status)))
        else $error("pending line lost while output stalled");
`endif

endmodule
